// File: rtl/mcpi_pkg.sv
package mcpi_pkg;

  // Default sizes
  localparam int MAX_STATES_DEF = 16;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed point format and row-sum tolerance (1e-6 in Q1.30)
  localparam int FRAC_BITS = 30;
  localparam int ROW_TOL   = 1073;

  // Field widths
  localparam int IDX_BITS       = 4;
  localparam int OP_BITS        = 2;
  localparam int KIND_BITS      = 2;
  localparam int ERR_BITS       = 2;
  localparam int ITER_BITS      = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int SC_BITS        = 5;
  localparam int TOL_BITS       = 31;

  // Request operations
  localparam logic [OP_BITS-1:0] OP_LOAD_MATRIX = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD_INIT   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_START       = 2'd2;

  // Result kinds
  localparam logic [KIND_BITS-1:0] KIND_STEP   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_STAT   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_STATUS = 2'd2;

  // Error codes
  localparam logic [ERR_BITS-1:0] ERR_OK  = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_NEG = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_ROW = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_STATE_COUNT = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_COUNT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ITER_LIMIT  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE   = 3'd3;

  // Register reset values
  localparam logic [SC_BITS-1:0]   RST_STATE_COUNT = 5'd1;
  localparam logic [ITER_BITS-1:0] RST_STEP_COUNT  = 16'd0;
  localparam logic [ITER_BITS-1:0] RST_ITER_LIMIT  = 16'd1000;
  localparam logic [TOL_BITS-1:0]  RST_TOLERANCE   = 31'd1074;

  // Per-cycle commands to the vector cells
  typedef struct packed {
    logic load_init;
    logic load_uni;
    logic copy;
    logic rot_cur;
    logic shift_nxt;
  } cell_ctl_t;

endpackage

// File: rtl/mcpi_if.sv
interface mcpi_req_if #(parameter int VALUE_BITS = mcpi_pkg::VALUE_BITS_DEF);
  logic                            valid;
  logic                            ready;
  logic [mcpi_pkg::OP_BITS-1:0]    operation;
  logic [mcpi_pkg::IDX_BITS-1:0]   row_index;
  logic [mcpi_pkg::IDX_BITS-1:0]   col_index;
  logic signed [VALUE_BITS-1:0]    entry_value;
  modport source (output valid, operation, row_index, col_index, entry_value, input ready);
  modport sink   (input valid, operation, row_index, col_index, entry_value, output ready);
endinterface

interface mcpi_rsp_if #(parameter int VALUE_BITS = mcpi_pkg::VALUE_BITS_DEF);
  logic                            valid;
  logic                            ready;
  logic [mcpi_pkg::KIND_BITS-1:0]  result_kind;
  logic [mcpi_pkg::IDX_BITS-1:0]   element_index;
  logic signed [VALUE_BITS-1:0]    element_value;
  logic [mcpi_pkg::ERR_BITS-1:0]   error_code;
  logic                            converged;
  logic [mcpi_pkg::ITER_BITS-1:0]  iterations_used;
  logic                            last_result;
  modport source (output valid, result_kind, element_index, element_value, error_code,
                  converged, iterations_used, last_result, input ready);
  modport sink   (input valid, result_kind, element_index, element_value, error_code,
                  converged, iterations_used, last_result, output ready);
endinterface

interface mcpi_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [mcpi_pkg::CFG_INDEX_BITS-1:0]   index;
  logic [mcpi_pkg::CFG_DATA_BITS-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/mcpi_ram.sv
module mcpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mcpi_cell.sv
module mcpi_cell #(
  parameter int VALUE_BITS = mcpi_pkg::VALUE_BITS_DEF,
  parameter int CELL_ID    = 0
) (
  input  logic                              clk,
  input  mcpi_pkg::cell_ctl_t               ctl,
  input  logic                              init_we,
  input  logic [mcpi_pkg::IDX_BITS-1:0]     init_idx,
  input  logic signed [VALUE_BITS-1:0]      init_data,
  input  logic signed [VALUE_BITS-1:0]      uni_val,
  input  logic signed [VALUE_BITS-1:0]      cur_in,
  input  logic signed [VALUE_BITS-1:0]      nxt_in,
  output logic signed [VALUE_BITS-1:0]      cur,
  output logic signed [VALUE_BITS-1:0]      nxt
);

  logic signed [VALUE_BITS-1:0] init_val;

  // Hold this state's initial distribution entry
  always_ff @(posedge clk) begin
    if (init_we && (int'(init_idx) == CELL_ID)) begin
      init_val <= init_data;
    end
  end

  // Current vector element: load, copy or rotate toward the head
  always_ff @(posedge clk) begin
    if (ctl.load_init) begin
      cur <= init_val;
    end else if (ctl.load_uni) begin
      cur <= uni_val;
    end else if (ctl.copy) begin
      cur <= nxt;
    end else if (ctl.rot_cur) begin
      cur <= cur_in;
    end
  end

  // Next vector element: shift toward the head
  always_ff @(posedge clk) begin
    if (ctl.shift_nxt) begin
      nxt <= nxt_in;
    end
  end

endmodule

// File: rtl/mcpi_mac.sv
module mcpi_mac #(
  parameter int VALUE_BITS = mcpi_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_first,
  input  logic                          in_last,
  input  logic signed [VALUE_BITS-1:0]  a,
  input  logic signed [VALUE_BITS-1:0]  b,
  output logic                          res_valid,
  output logic signed [VALUE_BITS-1:0]  res,
  output logic                          busy
);

  localparam int VB = VALUE_BITS;
  localparam int PW = 2 * VB;

  logic          v2, v3, v4;
  logic          f2, f3, f4, l2, l3, l4;
  logic          neg2, neg3, neg4;
  logic [VB-1:0] ma2, mb2;
  logic [PW-1:0] prod3;
  logic signed [VB-1:0] q4;
  logic signed [VB-1:0] acc;

  logic [PW-1:0] m_shift, lim, m_clip;
  logic [VB-1:0] q_mag;
  logic signed [VB:0] sum_wide;
  logic signed [VB-1:0] sum_sat;

  // Scale and clip to the signed range for the product's sign
  always_comb begin
    m_shift = prod3 >> mcpi_pkg::FRAC_BITS;
    lim     = neg3 ? (PW'(1) << (VB - 1)) : ((PW'(1) << (VB - 1)) - PW'(1));
    m_clip  = (m_shift > lim) ? lim : m_shift;
    q_mag   = m_clip[VB-1:0];
  end

  // Saturating accumulate
  always_comb begin
    sum_wide = (f4 ? (VB+1)'(0) : {acc[VB-1], acc}) + {q4[VB-1], q4};
    if (sum_wide[VB] != sum_wide[VB-1]) begin
      sum_sat = sum_wide[VB] ? {1'b1, {(VB-1){1'b0}}} : {1'b0, {(VB-1){1'b1}}};
    end else begin
      sum_sat = sum_wide[VB-1:0];
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v2 <= in_valid;
      v3 <= v2;
      v4 <= v3;
      res_valid <= v4 && l4;
    end
  end

  // Datapath: magnitudes, product, scaled term, accumulator
  always_ff @(posedge clk) begin
    f2    <= in_first;
    l2    <= in_last;
    neg2  <= a[VB-1] ^ b[VB-1];
    ma2   <= a[VB-1] ? (VB'(0) - a) : a;
    mb2   <= b[VB-1] ? (VB'(0) - b) : b;
    f3    <= f2;
    l3    <= l2;
    neg3  <= neg2;
    prod3 <= PW'(ma2) * PW'(mb2);
    f4    <= f3;
    l4    <= l3;
    neg4  <= neg3;
    q4    <= neg3 ? (VB'(0) - q_mag) : q_mag;
    if (v4) begin
      acc <= sum_sat;
    end
  end

  assign res  = acc;
  assign busy = v2 || v3 || v4 || res_valid;

  always_ff @(posedge clk) begin
    if (!rst && res_valid) begin
      assert (!v2 || !v3 || !v4 || 1'b1);
    end
  end

endmodule

// File: rtl/markov_chain_power_iteration.sv
// Loads: one request per cycle while idle, no result.
// Start: the row check reads every matrix entry; each vector-matrix product runs on
// the shared multiply-accumulate, and each power iteration adds an L1 change pass;
// results drain at one per cycle unless rsp stalls; a divider gives the uniform start.
// One start is worked at a time; requests wait until its status is issued.
// Reset (rst, synchronous) clears control and restores register defaults.
module markov_chain_power_iteration #(
  parameter int MAX_STATES = mcpi_pkg::MAX_STATES_DEF,
  parameter int VALUE_BITS = mcpi_pkg::VALUE_BITS_DEF
) (
  input logic             clk,
  input logic             rst,
  mcpi_req_if.sink        req,
  mcpi_rsp_if.source      rsp,
  mcpi_cfg_if.sink        cfg
);

  localparam int VB    = VALUE_BITS;
  localparam int NW    = $clog2(MAX_STATES + 1);
  localparam int CW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int DEPTH = MAX_STATES * MAX_STATES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int UW    = (VB > 31) ? VB : 31;
  localparam int SW    = UW + NW + 2;
  localparam int DW    = VB + NW + 1;
  localparam int IB    = mcpi_pkg::ITER_BITS;

  typedef enum logic [11:0] {
    S_IDLE       = 12'b000000000001,
    S_CHECK      = 12'b000000000010,
    S_CHECK_WAIT = 12'b000000000100,
    S_STEP_LOAD  = 12'b000000001000,
    S_MAT        = 12'b000000010000,
    S_DRAIN      = 12'b000000100000,
    S_DIFF       = 12'b000001000000,
    S_COPY       = 12'b000010000000,
    S_EMIT       = 12'b000100000000,
    S_DIVIDE     = 12'b001000000000,
    S_UNI        = 12'b010000000000,
    S_STATUS     = 12'b100000000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [mcpi_pkg::SC_BITS-1:0]  state_count;
  logic [IB-1:0]                 step_count;
  logic [IB-1:0]                 iter_limit;
  logic [mcpi_pkg::TOL_BITS-1:0] tolerance;

  // Control registers
  logic [NW-1:0] n;
  logic [CW-1:0] row_c, col_c, cnt;
  logic [IB-1:0] step_c, iters;
  logic          power, conv;
  logic [mcpi_pkg::ERR_BITS-1:0] err;
  logic signed [SW-1:0] row_sum;
  logic [DW-1:0] diff;
  logic [NW-1:0] rem;
  logic [30:0]   quo;
  logic [4:0]    dbit;

  // Stage after the matrix read
  logic s1_valid, s1_mat, s1_first, s1_last, s1_end;
  logic signed [VB-1:0] s1_u;

  // Result register
  logic                           o_valid;
  logic [mcpi_pkg::KIND_BITS-1:0] o_kind;
  logic [mcpi_pkg::IDX_BITS-1:0]  o_idx;
  logic signed [VB-1:0]           o_val;
  logic [mcpi_pkg::ERR_BITS-1:0]  o_err;
  logic                           o_conv;
  logic [IB-1:0]                  o_iters;
  logic                           o_last;

  logic signed [VB-1:0] cur [MAX_STATES];
  logic signed [VB-1:0] nxt [MAX_STATES];
  logic signed [VB-1:0] cur_in [MAX_STATES];
  logic signed [VB-1:0] nxt_in [MAX_STATES];

  mcpi_pkg::cell_ctl_t ctl;
  logic [NW-1:0] n_last;
  logic row_last, col_last, cnt_last, issue;
  logic req_fire, cfg_fire, out_free, emit_fire;
  logic [AW-1:0] raddr, waddr;
  logic ram_we;
  logic signed [VB-1:0] ram_q;
  logic mac_res_valid, mac_busy;
  logic signed [VB-1:0] mac_res;
  logic [NW-1:0] n_clamp;
  logic signed [SW-1:0] sum_next, dev;
  logic signed [VB:0] dval;
  logic [VB:0] dabs;
  logic [NW:0] div_sh;
  logic [UW-1:0] quo_ext;
  logic signed [VB-1:0] uni_val;
  logic tol_met;

  assign req_fire  = req.valid && req.ready;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign out_free  = !o_valid || rsp.ready;
  assign emit_fire = (state == S_EMIT) && out_free;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign n_last   = n - NW'(1);
  assign row_last = (NW'(row_c) == n_last);
  assign col_last = (NW'(col_c) == n_last);
  assign cnt_last = (NW'(cnt) == n_last);
  assign issue    = (state == S_CHECK) || (state == S_MAT);

  // Clamp state count at start
  always_comb begin
    if (state_count == '0) begin
      n_clamp = NW'(1);
    end else if (int'(state_count) > MAX_STATES) begin
      n_clamp = NW'(MAX_STATES);
    end else begin
      n_clamp = NW'(state_count);
    end
  end

  // Matrix store
  assign ram_we = req_fire && (req.operation == mcpi_pkg::OP_LOAD_MATRIX) &&
                  (int'(req.row_index) < MAX_STATES) && (int'(req.col_index) < MAX_STATES);
  assign waddr  = AW'(int'(req.row_index) * MAX_STATES + int'(req.col_index));
  assign raddr  = AW'(int'(row_c) * MAX_STATES + int'(col_c));

  mcpi_ram #(.WIDTH(VB), .DEPTH(DEPTH), .AW(AW)) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (req.entry_value),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Uniform start value, saturated
  always_comb begin
    quo_ext = UW'(quo);
    if (quo_ext > UW'({1'b0, {(VB-1){1'b1}}})) begin
      uni_val = {1'b0, {(VB-1){1'b1}}};
    end else begin
      uni_val = VB'(quo_ext);
    end
  end

  // Cell commands
  always_comb begin
    ctl.load_init = (state == S_STEP_LOAD);
    ctl.load_uni  = (state == S_UNI);
    ctl.copy      = (state == S_COPY);
    ctl.rot_cur   = (state == S_MAT) || (state == S_DIFF) || emit_fire;
    ctl.shift_nxt = mac_res_valid || (state == S_DIFF);
  end

  // Row of cells, rotating within the first n
  for (genvar k = 0; k < MAX_STATES; k++) begin : g_cell
    if (k < MAX_STATES - 1) begin : g_mid
      assign cur_in[k] = (NW'(k) == n_last) ? cur[0] : cur[k+1];
      assign nxt_in[k] = (NW'(k) == n_last) ? ((state == S_DIFF) ? nxt[0] : mac_res)
                                            : nxt[k+1];
    end else begin : g_end
      assign cur_in[k] = cur[0];
      assign nxt_in[k] = (state == S_DIFF) ? nxt[0] : mac_res;
    end

    mcpi_cell #(.VALUE_BITS(VB), .CELL_ID(k)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .init_we   (req_fire && (req.operation == mcpi_pkg::OP_LOAD_INIT)),
      .init_idx  (req.col_index),
      .init_data (req.entry_value),
      .uni_val   (uni_val),
      .cur_in    (cur_in[k]),
      .nxt_in    (nxt_in[k]),
      .cur       (cur[k]),
      .nxt       (nxt[k])
    );
  end

  mcpi_mac #(.VALUE_BITS(VB)) u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid && s1_mat),
    .in_first  (s1_first),
    .in_last   (s1_last),
    .a         (s1_u),
    .b         (ram_q),
    .res_valid (mac_res_valid),
    .res       (mac_res),
    .busy      (mac_busy)
  );

  // Row check arithmetic
  always_comb begin
    sum_next = (s1_first ? SW'(0) : row_sum) + SW'(ram_q);
    dev      = sum_next - (SW'(1) <<< mcpi_pkg::FRAC_BITS);
  end

  // L1 change term and divider step
  always_comb begin
    dval    = {nxt[0][VB-1], nxt[0]} - {cur[0][VB-1], cur[0]};
    dabs    = dval[VB] ? ((VB+1)'(0) - dval) : dval;
    div_sh  = {rem, (dbit == 5'd30)};
    tol_met = ((DW+32)'(diff) < (DW+32)'(tolerance));
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      state_count <= mcpi_pkg::RST_STATE_COUNT;
      step_count  <= mcpi_pkg::RST_STEP_COUNT;
      iter_limit  <= mcpi_pkg::RST_ITER_LIMIT;
      tolerance   <= mcpi_pkg::RST_TOLERANCE;
    end else if (cfg_fire) begin
      unique case (cfg.index)
        mcpi_pkg::REG_STATE_COUNT: state_count <= cfg.data[mcpi_pkg::SC_BITS-1:0];
        mcpi_pkg::REG_STEP_COUNT:  step_count  <= cfg.data[IB-1:0];
        mcpi_pkg::REG_ITER_LIMIT:  iter_limit  <= cfg.data[IB-1:0];
        mcpi_pkg::REG_TOLERANCE:   tolerance   <= cfg.data[mcpi_pkg::TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
    end
    s1_mat <= (state == S_MAT);
    s1_u   <= cur[0];
    if (state == S_MAT) begin
      s1_first <= (row_c == '0);
      s1_last  <= row_last;
      s1_end   <= row_last && col_last;
    end else begin
      s1_first <= (col_c == '0);
      s1_last  <= col_last;
      s1_end   <= col_last && row_last;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      o_valid <= 1'b0;
      row_c   <= '0;
      col_c   <= '0;
      cnt     <= '0;
      n       <= NW'(1);
      step_c  <= '0;
      iters   <= '0;
      power   <= 1'b0;
      conv    <= 1'b0;
      err     <= mcpi_pkg::ERR_OK;
    end else begin
      if (o_valid && rsp.ready) begin
        o_valid <= 1'b0;
      end

      // Advance issue counters
      if (state == S_CHECK) begin
        if (col_last) begin
          col_c <= '0;
          row_c <= row_c + CW'(1);
        end else begin
          col_c <= col_c + CW'(1);
        end
      end else if (state == S_MAT) begin
        if (row_last) begin
          row_c <= '0;
          col_c <= col_c + CW'(1);
        end else begin
          row_c <= row_c + CW'(1);
        end
      end else begin
        row_c <= '0;
        col_c <= '0;
      end

      if ((state != S_DIFF) && (state != S_EMIT)) begin
        cnt <= '0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire && (req.operation == mcpi_pkg::OP_START)) begin
            n     <= n_clamp;
            err   <= mcpi_pkg::ERR_OK;
            conv  <= 1'b0;
            iters <= '0;
            power <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_CHECK, S_CHECK_WAIT: begin
          if ((state == S_CHECK) && row_last && col_last) begin
            state <= S_CHECK_WAIT;
          end
          if (s1_valid && !s1_mat) begin
            row_sum <= sum_next;
            if (ram_q[VB-1]) begin
              err   <= mcpi_pkg::ERR_NEG;
              state <= S_STATUS;
            end else if (s1_last && ((dev > SW'(mcpi_pkg::ROW_TOL)) ||
                                     (dev < -SW'(mcpi_pkg::ROW_TOL)))) begin
              err   <= mcpi_pkg::ERR_ROW;
              state <= S_STATUS;
            end else if (s1_end) begin
              state <= S_STEP_LOAD;
            end
          end
        end
        S_STEP_LOAD: begin
          step_c <= '0;
          state  <= (step_count == '0) ? S_EMIT : S_MAT;
        end
        S_MAT: begin
          diff <= '0;
          if (row_last && col_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!s1_valid && !mac_busy) begin
            state <= power ? S_DIFF : S_COPY;
          end
        end
        S_DIFF: begin
          diff <= diff + DW'(dabs);
          cnt  <= cnt + CW'(1);
          if (cnt_last) begin
            state <= S_COPY;
          end
        end
        S_COPY: begin
          if (power) begin
            if (tol_met) begin
              conv  <= 1'b1;
              state <= S_EMIT;
            end else begin
              iters <= iters + IB'(1);
              state <= ((IB+1)'(iters) + (IB+1)'(1) < (IB+1)'(iter_limit)) ? S_MAT : S_EMIT;
            end
          end else begin
            step_c <= step_c + IB'(1);
            state  <= ((IB+1)'(step_c) + (IB+1)'(1) < (IB+1)'(step_count)) ? S_MAT : S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            o_valid <= 1'b1;
            o_kind  <= power ? mcpi_pkg::KIND_STAT : mcpi_pkg::KIND_STEP;
            o_idx   <= mcpi_pkg::IDX_BITS'(cnt);
            o_val   <= cur[0];
            o_err   <= mcpi_pkg::ERR_OK;
            o_conv  <= 1'b0;
            o_iters <= '0;
            o_last  <= 1'b0;
            cnt     <= cnt + CW'(1);
            if (cnt_last) begin
              if (power) begin
                state <= S_STATUS;
              end else begin
                rem   <= '0;
                quo   <= '0;
                dbit  <= 5'd30;
                state <= S_DIVIDE;
              end
            end
          end
        end
        S_DIVIDE: begin
          if (div_sh >= {1'b0, n}) begin
            rem <= NW'(div_sh - {1'b0, n});
            quo <= {quo[29:0], 1'b1};
          end else begin
            rem <= div_sh[NW-1:0];
            quo <= {quo[29:0], 1'b0};
          end
          dbit <= dbit - 5'd1;
          if (dbit == 5'd0) begin
            state <= S_UNI;
          end
        end
        S_UNI: begin
          power <= 1'b1;
          iters <= '0;
          conv  <= 1'b0;
          state <= (iter_limit == '0) ? S_EMIT : S_MAT;
        end
        S_STATUS: begin
          if (out_free) begin
            o_valid <= 1'b1;
            o_kind  <= mcpi_pkg::KIND_STATUS;
            o_idx   <= '0;
            o_val   <= '0;
            o_err   <= err;
            o_conv  <= conv;
            o_iters <= iters;
            o_last  <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Drive the result channel
  assign rsp.valid           = o_valid;
  assign rsp.result_kind     = o_kind;
  assign rsp.element_index   = o_idx;
  assign rsp.element_value   = o_val;
  assign rsp.error_code      = o_err;
  assign rsp.converged       = o_conv;
  assign rsp.iterations_used = o_iters;
  assign rsp.last_result     = o_last;

  // Only the status result closes a start
  a_last_is_status: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_last) |-> (o_kind == mcpi_pkg::KIND_STATUS))
    else $error("last result is not a status");

  // A failed check reports nothing of the power method
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_err != mcpi_pkg::ERR_OK) |-> (!o_conv && o_iters == '0))
    else $error("failed check carries power results");

  // Power iterations never run past the limit
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAT && power) |-> (iters < iter_limit))
    else $error("power iteration past limit");

  // Products only come back while a product is being formed
  a_mac_window: assert property (@(posedge clk) disable iff (rst)
    mac_res_valid |-> (state == S_MAT || state == S_DRAIN))
    else $error("stray product result");

endmodule
